// ----- sv/sem_pkg.sv -----
// shared types, codes and kernel constants for the sobel edge magnitude block
// no dependencies
package sem_pkg;

  localparam int NTAPS = 9;
  localparam int NCH   = 3;
  localparam int PIX_W = 8;

  // above this sum of squares the rounded root is at least 256
  localparam logic [16:0] MAG_LIMIT = 17'd65790;
  localparam logic [7:0]  MAG_MAX   = 8'd255;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_TAPS,
    B_SQR,
    B_SUM,
    B_ROOT,
    B_RND,
    B_OUT
  } back_state_e;

  typedef logic signed [10:0] grad_t;
  typedef logic signed [1:0]  tap_off_t;
  typedef logic signed [2:0]  kern_t;

  typedef struct packed {
    logic       last;
    logic [8:0] tap_ok;
  } tap_cmd_t;

  localparam tap_off_t TAP_DR [NTAPS] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0,
                                          2'sd1, 2'sd1, 2'sd1};
  localparam tap_off_t TAP_DC [NTAPS] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd1,
                                          -2'sd1, 2'sd0, 2'sd1};
  localparam kern_t KERN_X [NTAPS] = '{-3'sd1, 3'sd0, 3'sd1, -3'sd2, 3'sd0, 3'sd2,
                                       -3'sd1, 3'sd0, 3'sd1};
  localparam kern_t KERN_Y [NTAPS] = '{-3'sd1, -3'sd2, -3'sd1, 3'sd0, 3'sd0, 3'sd0,
                                       3'sd1, 3'sd2, 3'sd1};

  // pixel times a kernel weight, weights are small so this is add and shift
  function automatic grad_t kmul(logic [PIX_W-1:0] p, kern_t k);
    grad_t pe;
    pe = grad_t'({3'b000, p});
    case (k)
      3'sd1:   kmul = pe;
      -3'sd1:  kmul = -pe;
      3'sd2:   kmul = pe <<< 1;
      -3'sd2:  kmul = -(pe <<< 1);
      default: kmul = '0;
    endcase
  endfunction

endpackage

// ----- sv/sem_line_store.sv -----
// pixel history memory: one write port, one registered read port
// no dependencies
module sem_line_store #(
  parameter int AW = 12,
  parameter int DW = 24
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- sv/sem_queue.sv -----
// two-entry command queue between the front and the back
// no dependencies
module sem_queue #(
  parameter int W = 22
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] ent_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = ent_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue popped while empty");

endmodule

// ----- sv/sem_front.sv -----
// front end: takes items, writes pixels to the history, tracks output position
// and hands a tap command for every result to the queue; uses sem_pkg
module sem_front import sem_pkg::*; #(
  parameter int AW = 12,
  parameter int WW = 11,
  parameter int HW = 13,
  parameter int PW = 11,
  parameter int MAX_WIDTH = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  op_e             op_i,
  input  logic [23:0]     pix_i,
  input  logic [WW-1:0]   w_i,
  input  logic [HW-1:0]   h_i,
  output logic            we_o,
  output logic [AW-1:0]   waddr_o,
  output logic [23:0]     wdata_o,
  output logic            push_o,
  output logic [AW-1:0]   base_o,
  output tap_cmd_t        cmd_o
);

  logic [AW-1:0] wp_q, wp_d;
  logic [PW-1:0] pend_q, pend_d, pend_n;
  logic [WW-1:0] col_q, col_d;
  logic [HW-1:0] row_q, row_d;
  logic          is_pix, emit;
  logic [PW:0]   wx, px;
  logic [WW:0]   colx, wwx;
  logic [HW:0]   rowx, hhx;
  logic [2:0]    rok, cok;
  logic [8:0]    offok;

  always_comb begin
    is_pix = (op_i == OP_PIXEL);
    wp_d   = is_pix ? wp_q + AW'(1) : wp_q;
    pend_n = is_pix ? pend_q + PW'(1) : pend_q;
    wx     = (PW+1)'(w_i);
    px     = {1'b0, pend_n};
    emit   = is_pix ? (px > wx + (PW+1)'(1)) : (pend_q != '0);
    pend_d = emit ? pend_n - PW'(1) : pend_n;

    colx = {1'b0, col_q};
    wwx  = {1'b0, w_i};
    rowx = {1'b0, row_q};
    hhx  = {1'b0, h_i};
    // out-of-frame neighbors: index 0 is the previous row/column, 2 the next
    rok[0] = (row_q != '0) && (rowx - (HW+1)'(1) < hhx);
    rok[1] = rowx < hhx;
    rok[2] = rowx + (HW+1)'(1) < hhx;
    cok[0] = (col_q != '0) && (colx - (WW+1)'(1) < wwx);
    cok[1] = colx < wwx;
    cok[2] = colx + (WW+1)'(1) < wwx;
    // taps that have not arrived yet
    offok      = '1;
    offok[5]   = px > (PW+1)'(1);
    offok[6]   = wx - (PW+1)'(1) < px;
    offok[7]   = wx < px;
    offok[8]   = wx + (PW+1)'(1) < px;
    for (int k = 0; k < NTAPS; k++) begin
      cmd_o.tap_ok[k] = offok[k] & rok[2'(TAP_DR[k] + 2'sd1)] & cok[2'(TAP_DC[k] + 2'sd1)];
    end
    cmd_o.last = (rowx + (HW+1)'(1) == hhx) && (colx + (WW+1)'(1) == wwx);
    base_o     = wp_d - AW'(pend_n);

    col_d = col_q;
    row_d = row_q;
    if (emit) begin
      if (colx + (WW+1)'(1) >= wwx) begin
        col_d = '0;
        row_d = (rowx + (HW+1)'(1) >= hhx) ? '0 : row_q + HW'(1);
      end else begin
        col_d = col_q + WW'(1);
      end
    end
  end

  assign we_o    = accept_i && is_pix;
  assign waddr_o = wp_q;
  assign wdata_o = pix_i;
  assign push_o  = accept_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      pend_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else if (accept_i) begin
      wp_q   <= wp_d;
      pend_q <= pend_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PW+1)'(pend_q) <= (PW+1)'(MAX_WIDTH + 1))
    else $error("pending count beyond one row plus one");

endmodule

// ----- sv/sem_back.sv -----
// back end: gathers the nine taps from the history, forms gx/gy per channel,
// takes the rounded root one bit a cycle and holds the result; uses sem_pkg
module sem_back import sem_pkg::*; #(
  parameter int AW = 12,
  parameter int WW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [WW-1:0] w_i,
  input  logic          q_valid_i,
  input  logic [AW-1:0] q_base_i,
  input  tap_cmd_t      q_cmd_i,
  output logic          q_pop_o,
  output logic          re_o,
  output logic [AW-1:0] raddr_o,
  input  logic [23:0]   rdata_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [23:0]   out_data_o,
  output logic          out_last_o
);

  back_state_e   state_q, state_d;
  logic [3:0]    cnt_q;
  logic [2:0]    bit_q;
  logic [AW-1:0] base_q;
  tap_cmd_t      cmd_q;
  grad_t         gx_q [NCH];
  grad_t         gy_q [NCH];
  logic [20:0]   sqx_q [NCH];
  logic [20:0]   sqy_q [NCH];
  logic [16:0]   s_q [NCH];
  logic          cap_q [NCH];
  logic [7:0]    n_q [NCH];
  logic [7:0]    res_q [NCH];
  logic          ovalid_q;
  logic [23:0]   odata_q;
  logic          olast_q;
  logic          out_load;
  logic [3:0]    tidx, aidx;
  logic [AW-1:0] roff;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (q_valid_i) state_d = B_TAPS;
      B_TAPS: if (cnt_q == 4'd9) state_d = B_SQR;
      B_SQR:  state_d = B_SUM;
      B_SUM:  state_d = B_ROOT;
      B_ROOT: if (bit_q == 3'd0) state_d = B_RND;
      B_RND:  state_d = B_OUT;
      B_OUT:  if (!ovalid_q || out_ready_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // outputs toward queue, memory and output register
  always_comb begin
    tidx = (cnt_q < 4'd9) ? cnt_q : 4'd0;
    aidx = (cnt_q != 4'd0) ? cnt_q - 4'd1 : 4'd0;
    case (TAP_DR[tidx])
      -2'sd1:  roff = -AW'(w_i);
      2'sd1:   roff = AW'(w_i);
      default: roff = '0;
    endcase
    raddr_o  = base_q + roff + AW'(signed'(TAP_DC[tidx]));
    re_o     = (state_q == B_TAPS) && (cnt_q < 4'd9);
    q_pop_o  = (state_q == B_IDLE) && q_valid_i;
    out_load = (state_q == B_OUT) && (!ovalid_q || out_ready_i);
  end

  always_ff @(posedge clk_i) begin
    logic [7:0]  p, t;
    logic [15:0] tt;
    logic [16:0] nn;
    logic [21:0] sx, sy;
    case (state_q)
      B_IDLE: begin
        base_q <= q_base_i;
        cmd_q  <= q_cmd_i;
        for (int c = 0; c < NCH; c++) begin
          gx_q[c] <= '0;
          gy_q[c] <= '0;
        end
      end
      B_TAPS: begin
        if (cnt_q != 4'd0) begin
          for (int c = 0; c < NCH; c++) begin
            p = cmd_q.tap_ok[aidx] ? rdata_i[8*c +: 8] : 8'd0;
            gx_q[c] <= gx_q[c] + kmul(p, KERN_X[aidx]);
            gy_q[c] <= gy_q[c] + kmul(p, KERN_Y[aidx]);
          end
        end
      end
      B_SQR: begin
        for (int c = 0; c < NCH; c++) begin
          sx = 22'(gx_q[c] * gx_q[c]);
          sy = 22'(gy_q[c] * gy_q[c]);
          sqx_q[c] <= sx[20:0];
          sqy_q[c] <= sy[20:0];
        end
      end
      B_SUM: begin
        for (int c = 0; c < NCH; c++) begin
          s_q[c]   <= 17'(sqx_q[c] + sqy_q[c]);
          cap_q[c] <= (22'(sqx_q[c]) + 22'(sqy_q[c])) > 22'(MAG_LIMIT);
          n_q[c]   <= '0;
        end
      end
      B_ROOT: begin
        for (int c = 0; c < NCH; c++) begin
          t  = n_q[c] | (8'd1 << bit_q);
          tt = 16'(t) * 16'(t);
          if ({1'b0, tt} <= s_q[c]) n_q[c] <= t;
        end
      end
      B_RND: begin
        for (int c = 0; c < NCH; c++) begin
          nn = 17'(16'(n_q[c]) * 16'(n_q[c])) + 17'(n_q[c]);
          if (cap_q[c]) res_q[c] <= MAG_MAX;
          else if (s_q[c] > nn) res_q[c] <= (n_q[c] == MAG_MAX) ? MAG_MAX : n_q[c] + 8'd1;
          else res_q[c] <= n_q[c];
        end
      end
      default: ;
    endcase
    if (out_load) begin
      odata_q <= {res_q[2], res_q[1], res_q[0]};
      olast_q <= cmd_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      cnt_q    <= '0;
      bit_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_q == B_TAPS) ? cnt_q + 4'd1 : 4'd0;
      bit_q   <= (state_q == B_ROOT) ? bit_q - 3'd1 : 3'd7;
      if (out_load)         ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
  assign out_last_o  = olast_q;

  a_pop_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == B_TAPS && cnt_q == 4'd0))
    else $error("command popped without tap gathering");

  a_taps_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_TAPS && cnt_q == 4'd9) |=> state_q == B_SQR)
    else $error("tap gathering overran");

  a_root_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == B_ROOT) |-> bit_q == 3'd7)
    else $error("root iteration started mid-count");

  a_no_load_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!ovalid_q || out_ready_i))
    else $error("result overwritten before taken");

endmodule

// ----- sv/sobel_edge_magnitude_rgb_unit.sv -----
// sobel edge magnitude on an rgb raster stream, top level
// holds the config registers and joins front, queue, history memory and back; uses sem_pkg
//
// usage: pixels enter on the s_axis channel in raster order (tuser = 0), the
// result for a pixel leaves on m_axis once the pixel one row plus one column
// later has been taken. items with tuser = 1 drain one pending result each, used
// to flush the end of a frame. m_axis_tlast marks the frame's last pixel.
// frame_width / frame_height are set through cfg_we_i/cfg_idx_i/cfg_data_i while
// the block is idle; the width keeps only cfg_data_i[10:0], then 0 counts as 1
// and values above the maxima are clamped. throughput: the front takes items one
// per cycle while the two-entry command queue has room. each result goes through
// the back end as queue pop, nine taps read one per cycle from the single read
// port of the history memory, squares, sum, eight root bits, round and load; the
// back end takes the next command only after the load. reset clears positions,
// counts, queue and output valid; the history memory is not cleared. a stalled
// receiver holds the result register, the back end waits, then the queue fills
// and s_axis_tready drops.
module sobel_edge_magnitude_rgb_unit import sem_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // in_blue [7:0], in_green [15:8], in_red [23:16]
  input  logic        s_axis_tuser,   // op [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_blue [7:0], out_green [15:8], out_red [23:16]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [12:0] cfg_data_i
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = $clog2(MAX_WIDTH + 3);
  localparam int AW = $clog2(MAX_WIDTH) + 2;
  localparam int QW = AW + $bits(tap_cmd_t);

  logic [10:0]   fw_q;
  logic [12:0]   fh_q;
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic          accept, full, we, push, re, q_valid, q_pop;
  logic [AW-1:0] waddr, raddr, base, q_base;
  logic [23:0]   wdata, rdata;
  tap_cmd_t      cmd, q_cmd;
  logic [QW-1:0] q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= 11'd1024;
      fh_q <= 13'd768;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  fw_q <= cfg_data_i[10:0];
        CFG_HEIGHT: fh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_q == '0) w = WW'(1);
    else if (32'(fw_q) > MAX_WIDTH) w = WW'(MAX_WIDTH);
    else w = WW'(fw_q);
    if (fh_q == '0) h = HW'(1);
    else if (32'(fh_q) > MAX_HEIGHT) h = HW'(MAX_HEIGHT);
    else h = HW'(fh_q);
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  sem_front #(.AW(AW), .WW(WW), .HW(HW), .PW(PW), .MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .accept_i (accept),
    .op_i     (op_e'(s_axis_tuser)),
    .pix_i    (s_axis_tdata),
    .w_i      (w),
    .h_i      (h),
    .we_o     (we),
    .waddr_o  (waddr),
    .wdata_o  (wdata),
    .push_o   (push),
    .base_o   (base),
    .cmd_o    (cmd)
  );

  sem_queue #(.W(QW)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  ({cmd, base}),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign q_base = q_out[AW-1:0];
  assign q_cmd  = tap_cmd_t'(q_out[QW-1:AW]);

  sem_line_store #(.AW(AW), .DW(24)) u_store (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sem_back #(.AW(AW), .WW(WW)) u_back (
    .clk_i, .rst_ni,
    .w_i         (w),
    .q_valid_i   (q_valid),
    .q_base_i    (q_base),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
